// File: rtl/json_string_unescape_utf8_core_assert.svh
// ----------------------------------------------------------------------------
// JSON string decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_ASSERT_SVH

// Same-cycle implication, gated by reset
`define JSU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder same-cycle check failed");

// Next-cycle implication, gated by reset
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder next-cycle check failed");

`endif

// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, status codes and helpers shared by the JSON string decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Result status codes
    typedef logic [3:0] t_status;
    localparam t_status ST_BYTE   = 4'd0;
    localparam t_status ST_END    = 4'd1;
    localparam t_status ST_NOQ    = 4'd2;
    localparam t_status ST_BADHEX = 4'd3;
    localparam t_status ST_BADLO  = 4'd4;
    localparam t_status ST_INVLO  = 4'd5;
    localparam t_status ST_UNHI   = 4'd6;
    localparam t_status ST_UNLO   = 4'd7;
    localparam t_status ST_BADESC = 4'd8;
    localparam t_status ST_CTRL   = 4'd9;
    localparam t_status ST_UNTERM = 4'd10;

    // Code point width (up to U+10FFFF)
    localparam int CP_W = 21;

    // Default depth of the command queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // One command: a status and, for bytes, a code point with its UTF-8 length
    typedef struct packed {
        t_status         status;
        logic [CP_W-1:0] cp;
        logic [1:0]      nbytes_m1;   // UTF-8 length minus one
    } t_cmd;

    // Hex digit decode: bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= "0" && c <= "9") begin
            r = {1'b0, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b0, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b0, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

endpackage

// File: rtl/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Decodes one JSON string literal from a raw byte stream into UTF-8 bytes
// and status results.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  input    | in        | i_valid / o_ready  | i_action, i_data_byte
//  output   | out       | o_valid / i_ready  | o_out_byte, o_status, o_last
//
//  One input beat is taken per cycle while the command queue has room.
//  Output runs at one beat per cycle while i_ready is high; a surrogate pair
//  giving a four-byte sequence is sent as four output beats, which the queue absorbs.
//  Input passes through the command queue, then the output register.
//  Synchronous active-low reset empties the queue and returns to waiting.
//  Either side may stall on its own; o_ready drops only when the queue fills.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_action,
    input  logic [7:0]       i_data_byte,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output jsu_pkg::t_status o_status,
    output logic             o_last
);
    import jsu_pkg::*;

    logic accept;
    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_empty;
    t_cmd head;
    logic pop;

    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    // Parser
    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Command queue
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // UTF-8 emitter
    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (head),
        .o_pop        (pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser state machine: takes one input beat a cycle while i_accept is high,
// tracks escapes and \u digits, and pushes one command per item that yields a result.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_action,
    input  logic [7:0]    i_data_byte,
    output logic          o_push,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    // Parser modes
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_STR    = 3'd1;
    localparam logic [2:0] M_ESC    = 3'd2;
    localparam logic [2:0] M_HEX1   = 3'd3;
    localparam logic [2:0] M_WANTBS = 3'd4;
    localparam logic [2:0] M_WANTU  = 3'd5;
    localparam logic [2:0] M_HEX2   = 3'd6;

    logic [2:0]  r_mode,    n_mode;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [11:0] r_hex_acc, n_hex_acc;
    logic [9:0]  r_high,    n_high;

    logic        fail;
    t_status     fail_status;
    logic [4:0]  hexd;
    logic [15:0] v;
    logic        v_is_high;
    logic        v_is_low;

    assign hexd      = hex_value(i_data_byte);
    assign v         = {r_hex_acc, hexd[3:0]};
    assign v_is_high = (v[15:10] == 6'b110110);
    assign v_is_low  = (v[15:10] == 6'b110111);

    // Next-state and command decode
    always_comb begin
        n_mode      = r_mode;
        n_hex_cnt   = r_hex_cnt;
        n_hex_acc   = r_hex_acc;
        n_high      = r_high;
        fail        = 1'b0;
        fail_status = ST_NOQ;
        o_push      = 1'b0;
        o_cmd       = '0;
        if (i_accept) begin
            if (i_action) begin
                // end of input: every mode ends in an error result
                fail = 1'b1;
                case (r_mode)
                    M_STR, M_ESC:       fail_status = ST_UNTERM;
                    M_HEX1:             fail_status = ST_BADHEX;
                    M_WANTBS, M_WANTU:  fail_status = ST_UNHI;
                    M_HEX2:             fail_status = ST_BADLO;
                    default:            fail_status = ST_NOQ;
                endcase
            end else begin
                case (r_mode)
                    M_STR: begin
                        if (i_data_byte == "\"") begin
                            n_mode       = M_IDLE;
                            o_push       = 1'b1;
                            o_cmd.status = ST_END;
                        end else if (i_data_byte == "\\") begin
                            n_mode = M_ESC;
                        end else if (i_data_byte < 8'h20) begin
                            fail        = 1'b1;
                            fail_status = ST_CTRL;
                        end else begin
                            o_push       = 1'b1;
                            o_cmd.status = ST_BYTE;
                            o_cmd.cp     = CP_W'(i_data_byte);
                        end
                    end
                    M_ESC: begin
                        n_mode       = M_STR;
                        o_push       = 1'b1;
                        o_cmd.status = ST_BYTE;
                        case (i_data_byte)
                            "\"", "\\", "/": o_cmd.cp = CP_W'(i_data_byte);
                            "b":             o_cmd.cp = CP_W'(8'h08);
                            "f":             o_cmd.cp = CP_W'(8'h0C);
                            "n":             o_cmd.cp = CP_W'(8'h0A);
                            "r":             o_cmd.cp = CP_W'(8'h0D);
                            "t":             o_cmd.cp = CP_W'(8'h09);
                            "u": begin
                                o_push    = 1'b0;
                                n_mode    = M_HEX1;
                                n_hex_cnt = 2'd0;
                                n_hex_acc = '0;
                            end
                            default: begin
                                o_push      = 1'b0;
                                fail        = 1'b1;
                                fail_status = ST_BADESC;
                            end
                        endcase
                    end
                    M_HEX1, M_HEX2: begin
                        if (hexd[4]) begin
                            fail        = 1'b1;
                            fail_status = (r_mode == M_HEX1) ? ST_BADHEX : ST_BADLO;
                        end else if (r_hex_cnt != 2'd3) begin
                            n_hex_acc = {r_hex_acc[7:0], hexd[3:0]};
                            n_hex_cnt = r_hex_cnt + 2'd1;
                        end else begin
                            n_hex_cnt = 2'd0;
                            n_hex_acc = '0;
                            if (r_mode == M_HEX1) begin
                                if (v_is_high) begin
                                    n_high = v[9:0];
                                    n_mode = M_WANTBS;
                                end else if (v_is_low) begin
                                    fail        = 1'b1;
                                    fail_status = ST_UNLO;
                                end else begin
                                    n_mode       = M_STR;
                                    o_push       = 1'b1;
                                    o_cmd.status = ST_BYTE;
                                    o_cmd.cp     = CP_W'(v);
                                    if (v[15:7] == 9'd0) begin
                                        o_cmd.nbytes_m1 = 2'd0;
                                    end else if (v[15:11] == 5'd0) begin
                                        o_cmd.nbytes_m1 = 2'd1;
                                    end else begin
                                        o_cmd.nbytes_m1 = 2'd2;
                                    end
                                end
                            end else begin
                                if (!v_is_low) begin
                                    fail        = 1'b1;
                                    fail_status = ST_INVLO;
                                end else begin
                                    // supplementary plane: 0x10000 + (high << 10 | low)
                                    n_mode          = M_STR;
                                    o_push          = 1'b1;
                                    o_cmd.status    = ST_BYTE;
                                    o_cmd.cp        = 21'h10000 + {1'b0, r_high, v[9:0]};
                                    o_cmd.nbytes_m1 = 2'd3;
                                end
                            end
                        end
                    end
                    M_WANTBS: begin
                        if (i_data_byte == "\\") begin
                            n_mode = M_WANTU;
                        end else begin
                            fail        = 1'b1;
                            fail_status = ST_UNHI;
                        end
                    end
                    M_WANTU: begin
                        if (i_data_byte == "u") begin
                            n_mode    = M_HEX2;
                            n_hex_cnt = 2'd0;
                            n_hex_acc = '0;
                        end else begin
                            fail        = 1'b1;
                            fail_status = ST_UNHI;
                        end
                    end
                    default: begin
                        if (i_data_byte == "\"") begin
                            n_mode = M_STR;
                        end else begin
                            fail        = 1'b1;
                            fail_status = ST_NOQ;
                        end
                    end
                endcase
            end
            // errors: one status result and back to waiting for a quote
            if (fail) begin
                n_mode       = M_IDLE;
                n_hex_cnt    = 2'd0;
                o_push       = 1'b1;
                o_cmd        = '0;
                o_cmd.status = fail_status;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_hex_cnt <= 2'd0;
            r_hex_acc <= '0;
            r_high    <= '0;
        end else begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_hex_acc <= n_hex_acc;
            r_high    <= n_high;
        end
    end

endmodule

// File: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small command queue between parser and UTF-8 emitter; head shown directly.
// ----------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output jsu_pkg::t_cmd o_head
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// UTF-8 emitter: expands the head command into one to four output beats
// through a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  jsu_pkg::t_cmd     i_head,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output jsu_pkg::t_status  o_status,
    output logic              o_last
);
    import jsu_pkg::*;

    // UTF-8 lead and continuation prefixes
    localparam logic [1:0] PFX_CONT  = 2'b10;
    localparam logic [2:0] PFX_LEAD2 = 3'b110;
    localparam logic [3:0] PFX_LEAD3 = 4'b1110;
    localparam logic [4:0] PFX_LEAD4 = 5'b11110;

    logic       r_valid;
    logic [7:0] r_byte;
    t_status    r_status;
    logic       r_last;
    logic [1:0] r_idx;

    logic       load;
    logic       beat_last;
    logic [7:0] beat_byte;

    assign load      = i_head_valid && (!r_valid || i_ready);
    assign beat_last = (r_idx == i_head.nbytes_m1);
    assign o_pop     = load && beat_last;

    // Byte selection for the current position in the sequence
    always_comb begin
        case (i_head.nbytes_m1)
            2'd0: beat_byte = i_head.cp[7:0];
            2'd1: begin
                case (r_idx)
                    2'd0:    beat_byte = {PFX_LEAD2, i_head.cp[10:6]};
                    default: beat_byte = {PFX_CONT, i_head.cp[5:0]};
                endcase
            end
            2'd2: begin
                case (r_idx)
                    2'd0:    beat_byte = {PFX_LEAD3, i_head.cp[15:12]};
                    2'd1:    beat_byte = {PFX_CONT, i_head.cp[11:6]};
                    default: beat_byte = {PFX_CONT, i_head.cp[5:0]};
                endcase
            end
            default: begin
                case (r_idx)
                    2'd0:    beat_byte = {PFX_LEAD4, i_head.cp[20:18]};
                    2'd1:    beat_byte = {PFX_CONT, i_head.cp[17:12]};
                    2'd2:    beat_byte = {PFX_CONT, i_head.cp[11:6]};
                    default: beat_byte = {PFX_CONT, i_head.cp[5:0]};
                endcase
            end
        endcase
    end

    // Output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= beat_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= beat_byte;
            r_status <= i_head.status;
            r_last   <= beat_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_status   = r_status;
    assign o_last     = r_last;

endmodule

// File: rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_core_assert.svh"

module jsu_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic [7:0]       o_out_byte,
    input jsu_pkg::t_status o_status,
    input logic             o_last
);
    import jsu_pkg::*;

    logic [12:0] out_word;

    assign out_word = {o_out_byte, o_status, o_last};

    // A stalled output beat holds its payload
    `JSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(out_word))

    // Status results (end and errors) stand alone and close their item
    `JSU_ASSERT_IMPLY(a_status_last, i_clk, i_rst_n, o_valid && o_status != ST_BYTE, o_last && o_out_byte == 8'h00)

    // Status codes stay within the defined set
    `JSU_ASSERT_IMPLY(a_status_range, i_clk, i_rst_n, o_valid, o_status <= ST_UNTERM)

    // A presented beat carries a fully known payload
    `JSU_ASSERT_IMPLY(a_out_known, i_clk, i_rst_n, o_valid, !$isunknown(out_word))

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_byte (o_out_byte),
    .o_status   (o_status),
    .o_last     (o_last)
);
